// ===== rtl/rtpos_pkg.sv =====
package rtpos_pkg;

  localparam int MAX_ENTRIES_DEF = 64;

  localparam int ENTRY_W    = 6;
  localparam int OFFSET_W   = 7;
  localparam int POSITION_W = 6;
  localparam int VALUE_W    = 6;
  localparam int COUNT_W    = 7;

  localparam int ENTRY_LSB    = 0;
  localparam int OFFSET_LSB   = ENTRY_LSB + ENTRY_W;
  localparam int POSITION_LSB = OFFSET_LSB + OFFSET_W;
  localparam int IN_FIELDS_W  = POSITION_LSB + POSITION_W;

  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((VALUE_W + 7) / 8) * 8;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

  localparam logic CMD_MOVE  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic idle;
    logic load_item;
    logic rd_from;
    logic eval_from;
    logic rd_sweep;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_query;
    logic absent;
    logic no_move;
    logic sweep_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/rtpos_ram.sv =====
module rtpos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/rtpos_dp.sv =====
module rtpos_dp #(
  parameter int MAX_ENTRIES = rtpos_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rtpos_pkg::ctrl_cmd_t                cmd,
  output rtpos_pkg::dp_stat_t                 stat,
  input  logic [rtpos_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  logic [0:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [rtpos_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic [0:0]                          m_tuser,
  input  logic                                cfg_valid,
  input  logic [rtpos_pkg::COUNT_W-1:0]       cfg_data
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = ($clog2(MAX_ENTRIES + 1) > rtpos_pkg::COUNT_W) ?
                         $clog2(MAX_ENTRIES + 1) : rtpos_pkg::COUNT_W;
  localparam int SW    = CNT_W + 2;

  function automatic logic [CNT_W-1:0] live_count(input logic [rtpos_pkg::COUNT_W-1:0] raw);
    logic [CNT_W-1:0] ext;
    ext = CNT_W'(raw);
    if (raw == '0) begin
      ext = CNT_W'(1);
    end else if (ext > CNT_W'(MAX_ENTRIES)) begin
      ext = CNT_W'(MAX_ENTRIES);
    end
    return ext;
  endfunction

  logic [CNT_W-1:0]                  cnt_r;
  logic                              cmd_q;
  logic [CNT_W-1:0]                  who_q;
  logic signed [rtpos_pkg::OFFSET_W-1:0] off_q;
  logic [CNT_W-1:0]                  pos_q;
  logic                              clamped_q;
  logic [IDX_W-1:0]                  from_q;
  logic [IDX_W-1:0]                  to_q;
  logic                              up_q;
  logic                              found_q;
  logic [IDX_W-1:0]                  found_val_q;
  logic [IDX_W-1:0]                  ctr_q;
  logic                              stg_vld;
  logic                              stg_sweep;
  logic [IDX_W-1:0]                  stg_idx;
  logic                              stg_init;
  logic [CNT_W-1:0]                  fill_q;

  logic [rtpos_pkg::ENTRY_W-1:0]     in_entry;
  logic [rtpos_pkg::OFFSET_W-1:0]    in_offset;
  logic [rtpos_pkg::POSITION_W-1:0]  in_position;
  logic [CNT_W-1:0]                  pos_ext;

  logic                              rd_en;
  logic [IDX_W-1:0]                  rd_addr;
  logic [IDX_W-1:0]                  ram_rdata;
  logic                              ram_we;
  logic [IDX_W-1:0]                  wr_val;
  logic [IDX_W-1:0]                  r_cur;

  logic signed [SW-1:0]              from_s;
  logic signed [SW-1:0]              off_s;
  logic signed [SW-1:0]              to_raw;
  logic signed [SW-1:0]              cnt_top;
  logic signed [SW-1:0]              to_cl;
  logic                              clamp_eval;
  logic [IDX_W-1:0]                  to_eval;
  logic                              query_hit;
  logic [IDX_W-1:0]                  out_val;
  logic                              cfg_fire;

  assign in_entry    = s_tdata[rtpos_pkg::ENTRY_LSB +: rtpos_pkg::ENTRY_W];
  assign in_offset   = s_tdata[rtpos_pkg::OFFSET_LSB +: rtpos_pkg::OFFSET_W];
  assign in_position = s_tdata[rtpos_pkg::POSITION_LSB +: rtpos_pkg::POSITION_W];
  assign pos_ext     = CNT_W'(in_position);
  assign cfg_fire    = cfg_valid & cmd.idle;

  assign rd_en   = cmd.rd_from | cmd.rd_sweep;
  assign rd_addr = cmd.rd_from ? who_q[IDX_W-1:0] : ctr_q;
  assign r_cur   = stg_init ? ram_rdata : stg_idx;
  assign ram_we  = stg_vld & stg_sweep & (cmd_q == rtpos_pkg::CMD_MOVE);

  rtpos_ram #(
    .WIDTH(IDX_W),
    .DEPTH(MAX_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(stg_idx),
    .wdata(wr_val),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  always_comb begin
    from_s     = SW'(r_cur);
    off_s      = SW'(off_q);
    to_raw     = from_s + off_s;
    cnt_top    = SW'(cnt_r);
    cnt_top    = cnt_top - SW'(1);
    clamp_eval = 1'b0;
    to_cl      = to_raw;
    if (to_raw < 0) begin
      to_cl      = '0;
      clamp_eval = 1'b1;
    end else if (to_raw > cnt_top) begin
      to_cl      = cnt_top;
      clamp_eval = 1'b1;
    end
    to_eval = to_cl[IDX_W-1:0];
  end

  always_comb begin
    wr_val = r_cur;
    if (stg_idx == who_q[IDX_W-1:0]) begin
      wr_val = to_q;
    end else if (up_q && r_cur >= from_q && r_cur <= to_q) begin
      wr_val = r_cur - IDX_W'(1);
    end else if (!up_q && r_cur >= to_q && r_cur <= from_q) begin
      wr_val = r_cur + IDX_W'(1);
    end
  end

  assign query_hit = stg_vld & stg_sweep & (cmd_q == rtpos_pkg::CMD_QUERY) & ~found_q &
                     (CNT_W'(r_cur) == pos_q);

  assign stat.is_query   = (cmd_q == rtpos_pkg::CMD_QUERY);
  assign stat.absent     = (who_q >= cnt_r);
  assign stat.no_move    = (to_eval == r_cur);
  assign stat.sweep_last = (CNT_W'(ctr_q) == cnt_r - CNT_W'(1));
  assign stat.out_free   = ~m_tvalid | m_tready;

  always_comb begin
    if (cmd_q == rtpos_pkg::CMD_QUERY) begin
      out_val = found_val_q;
    end else if (stat.absent) begin
      out_val = '0;
    end else begin
      out_val = to_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_r    <= live_count(rtpos_pkg::COUNT_RESET);
      fill_q   <= '0;
      stg_vld  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_fire) begin
        cnt_r  <= live_count(cfg_data);
        fill_q <= '0;
      end else if (ram_we && (CNT_W'(stg_idx) == fill_q)) begin
        fill_q <= fill_q + CNT_W'(1);
      end
      stg_vld <= rd_en;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    stg_sweep <= cmd.rd_sweep;
    stg_idx   <= rd_addr;
    stg_init  <= (CNT_W'(rd_addr) < fill_q);
    if (cmd.load_item) begin
      cmd_q       <= s_tuser[0];
      who_q       <= CNT_W'(in_entry);
      off_q       <= in_offset;
      ctr_q       <= '0;
      found_q     <= 1'b0;
      found_val_q <= '0;
      if (pos_ext >= cnt_r) begin
        pos_q     <= cnt_r - CNT_W'(1);
        clamped_q <= s_tuser[0];
      end else begin
        pos_q     <= pos_ext;
        clamped_q <= 1'b0;
      end
    end else begin
      if (cmd.rd_sweep) begin
        ctr_q <= ctr_q + IDX_W'(1);
      end
      if (cmd.eval_from) begin
        from_q    <= r_cur;
        to_q      <= to_eval;
        up_q      <= (to_cl > from_s);
        clamped_q <= clamp_eval;
      end
      if (query_hit) begin
        found_q     <= 1'b1;
        found_val_q <= stg_idx;
      end
    end
    if (cmd.load_out) begin
      m_tdata <= rtpos_pkg::OUT_TDATA_W'(rtpos_pkg::VALUE_W'(out_val));
      m_tuser <= clamped_q;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !cmd.load_out)
    else $error("result register overwritten while still waiting");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    cfg_fire |=> (cnt_r != '0 && cnt_r <= CNT_W'(MAX_ENTRIES)))
    else $error("live entry count out of range");

  a_port_conflict: assert property (@(posedge clk) disable iff (rst)
    (ram_we && rd_en) |-> (stg_idx != rd_addr))
    else $error("table read and write at the same address");

  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    (stg_vld && stg_sweep) |-> (CNT_W'(stg_idx) < cnt_r))
    else $error("sweep touched an entry beyond the live count");

endmodule

// ===== rtl/rtpos_ctrl.sv =====
module rtpos_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  rtpos_pkg::dp_stat_t  stat,
  output rtpos_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_FROM   = 6'b000100,
    S_SWEEP  = 6'b001000,
    S_DRAIN  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.idle      = 1'b1;
        cmd.load_item = s_tvalid;
        if (s_tvalid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.is_query) begin
          state_next = S_SWEEP;
        end else if (stat.absent) begin
          state_next = S_FINISH;
        end else begin
          cmd.rd_from = 1'b1;
          state_next  = S_FROM;
        end
      end
      S_FROM: begin
        cmd.eval_from = 1'b1;
        state_next    = stat.no_move ? S_FINISH : S_SWEEP;
      end
      S_SWEEP: begin
        cmd.rd_sweep = 1'b1;
        if (stat.sweep_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/rank_table_reposition_unit.sv =====
// Rank table: keeps the position of each of up to MAX_ENTRIES entries in an ordered line.
// Requests arrive on the s_ channel. tuser selects the request: 0 moves an entry by a
// signed offset, 1 asks which entry stands at a position. Each request gives exactly one
// result on the m_ channel: the new position of a moved entry, or the entry found, with
// tuser set when the target or the position had to be clamped into the live range.
// The cfg channel writes the live entry count, which also restores the identity order.
// Write it only while no request is in flight.
// The controller sweeps the table memory one entry per cycle through its single read port,
// and a move writes the updated position back in the cycle after each read.
// A move of an entry beyond the count, or one that ends where it started, skips the sweep.
// The next request is taken in the cycle after a result is loaded.
// The result sits in an output register. If the receiver stalls, the block still takes
// the next request and works on it, then waits with that result until the register frees.
// Reset sets the count to 64 (limited to MAX_ENTRIES) and the identity order, at once:
// a fill count makes table entries not yet written by a sweep read as their own index.
module rank_table_reposition_unit #(
  parameter int MAX_ENTRIES = rtpos_pkg::MAX_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // entry [5:0], offset [12:6], position [18:13]
  input  logic [rtpos_pkg::IN_TDATA_W-1:0]  s_tdata,
  // cmd [0]
  input  logic [0:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // value [5:0]
  output logic [rtpos_pkg::OUT_TDATA_W-1:0] m_tdata,
  // clamped [0]
  output logic [0:0]                        m_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rtpos_pkg::COUNT_W-1:0]     cfg_data
);

  rtpos_pkg::ctrl_cmd_t cmd;
  rtpos_pkg::dp_stat_t  stat;

  assign s_tready  = cmd.idle;
  assign cfg_ready = cmd.idle;

  rtpos_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .stat    (stat),
    .cmd     (cmd)
  );

  rtpos_dp #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data)
  );

endmodule
